@@ hw/rtl/leader_cluster_nearest_centroid_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the leader clustering block
// Shared property forms, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LEADER_CLUSTER_NEAREST_CENTROID_MACROS_SVH
`define LEADER_CLUSTER_NEAREST_CENTROID_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define LCCN_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LCCN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lccn_pkg.sv @@
// ----------------------------------------------------------------------------
// lccn_pkg
// Types, sizes and codes shared by the leader clustering block.
// ----------------------------------------------------------------------------
package lccn_pkg;

	localparam int MAX_CENTROIDS = 64;
	localparam int IDX_W  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
	localparam int CNT_W  = $clog2(MAX_CENTROIDS + 1);
	localparam int COORD_W = 16;
	localparam int SQ_W   = 32;
	localparam int DIST_W = 34;
	localparam int RAD_W  = 33;
	localparam int OUT_IDX_W = 6;

	localparam logic [RAD_W-1:0] RADIUS_RESET = 33'd147456;

	// Operation codes
	localparam logic [1:0] OP_LEARN    = 2'd0;
	localparam logic [1:0] OP_FORCE    = 2'd1;
	localparam logic [1:0] OP_CLASSIFY = 2'd2;

	typedef struct packed {
		logic [1:0]                 opcode;
		logic signed [COORD_W-1:0]  point_x;
		logic signed [COORD_W-1:0]  point_y;
		logic [1:0]                 point_label;
	} cmd_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] cluster_index;
		logic [1:0]           cluster_label;
		logic                 created;
		logic                 table_full;
		logic                 table_empty;
	} result_t;

	// Query word moving along the cell row
	typedef struct packed {
		logic                       valid;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
	} query_t;

	// Running nearest match, one cell behind the query
	typedef struct packed {
		logic              valid;
		logic              have;
		logic [DIST_W-1:0] dsq;
		logic [IDX_W-1:0]  idx;
		logic [1:0]        lab;
	} best_t;

	// Table write broadcast to the cells
	typedef struct packed {
		logic                       en;
		logic [IDX_W-1:0]           addr;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic [1:0]                 lab;
	} wr_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

@@ hw/rtl/lccn_cell.sv @@
// ----------------------------------------------------------------------------
// lccn_cell
// One centroid slot: stores a point and label, squares the offset to the
// passing query, then folds its distance into the running nearest match.
// ----------------------------------------------------------------------------
module lccn_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [lccn_pkg::IDX_W-1:0] cell_idx,
	input  logic                 live,
	input  logic                 wr_sel,
	input  lccn_pkg::wr_t        wr,
	input  lccn_pkg::query_t     q_in,
	input  lccn_pkg::best_t      b_in,
	output lccn_pkg::query_t     q_out,
	output lccn_pkg::best_t      b_out
);
	import lccn_pkg::*;

	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [1:0]                cl_q;
	logic [SQ_W-1:0]           sqx_q, sqy_q;
	logic signed [COORD_W:0]   dx, dy;
	logic signed [2*COORD_W+1:0] px2, py2;
	logic [DIST_W-1:0]         cand_dsq;
	logic                      take;
	logic                      qv_q, bv_q;
	logic signed [COORD_W-1:0] qx_q, qy_q;
	best_t                     b_q;

	// Store the centroid when this slot is written
	always_ff @(posedge clk) begin
		if (wr_sel) begin
			cx_q <= wr.x;
			cy_q <= wr.y;
			cl_q <= wr.lab;
		end
	end

	// Square the offsets to the query now in this cell
	assign dx  = {cx_q[COORD_W-1], cx_q} - {q_in.x[COORD_W-1], q_in.x};
	assign dy  = {cy_q[COORD_W-1], cy_q} - {q_in.y[COORD_W-1], q_in.y};
	assign px2 = dx * dx;
	assign py2 = dy * dy;

	always_ff @(posedge clk) begin
		sqx_q <= px2[SQ_W-1:0];
		sqy_q <= py2[SQ_W-1:0];
	end

	// Fold this slot into the match, which arrives in the cycle after the query
	assign cand_dsq = {2'b00, sqx_q} + {2'b00, sqy_q};
	assign take     = live && (!b_in.have || (cand_dsq < b_in.dsq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_q <= 1'b0;
			bv_q <= 1'b0;
		end else begin
			qv_q <= q_in.valid;
			bv_q <= b_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		qx_q <= q_in.x;
		qy_q <= q_in.y;
		if (take) begin
			b_q.valid <= b_in.valid;
			b_q.have  <= 1'b1;
			b_q.dsq   <= cand_dsq;
			b_q.idx   <= cell_idx;
			b_q.lab   <= cl_q;
		end else begin
			b_q <= b_in;
		end
	end

	// Hand the query and the match on to the next cell
	always_comb begin
		q_out.valid = qv_q;
		q_out.x     = qx_q;
		q_out.y     = qy_q;
		b_out       = b_q;
		b_out.valid = bv_q;
	end

endmodule

@@ hw/rtl/lccn_ctrl.sv @@
// ----------------------------------------------------------------------------
// lccn_ctrl
// Sequencer: takes a command word, launches the query into the cell row,
// decides on the nearest match at the far end, writes the table, reports.
// ----------------------------------------------------------------------------
module lccn_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  lccn_pkg::cmd_t             cmd,
	input  logic                       cfg_valid,
	input  logic [lccn_pkg::RAD_W-1:0] cfg_data,
	input  lccn_pkg::best_t            b_end,
	output logic                       busy,
	output logic [lccn_pkg::CNT_W-1:0] count,
	output lccn_pkg::query_t           q_head,
	output lccn_pkg::best_t            b_head,
	output lccn_pkg::wr_t              wr,
	output logic                       done,
	output lccn_pkg::result_t          result
);
	import lccn_pkg::*;

	state_t          state_q, state_d;
	logic [1:0]      op_q;
	logic [1:0]      lab_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic [CNT_W-1:0] count_q;
	logic [RAD_W-1:0] radius_q;
	logic            qv_q, bv_q;
	logic            done_q;
	result_t         result_q, res_d;
	logic            finish, want, room;
	logic [IDX_W+OUT_IDX_W-1:0] near_ext, new_ext;

	// Radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	// Latch the command word on accept
	always_ff @(posedge clk) begin
		if (start && (state_q == ST_IDLE)) begin
			op_q  <= cmd.opcode;
			lab_q <= cmd.point_label;
			px_q  <= cmd.point_x;
			py_q  <= cmd.point_y;
		end
	end

	// State, count, launch markers and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			qv_q    <= 1'b0;
			bv_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			qv_q    <= start && (state_q == ST_IDLE);
			bv_q    <= qv_q;
			done_q  <= finish;
			if (finish && res_d.created) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q <= res_d;
		end
	end

	// Next state and decision at the end of the row
	assign room     = count_q < CNT_W'(MAX_CENTROIDS);
	assign near_ext = {{OUT_IDX_W{1'b0}}, b_end.idx};
	assign new_ext  = {{OUT_IDX_W{1'b0}}, count_q[IDX_W-1:0]};

	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		want    = 1'b0;
		res_d   = '0;
		if (b_end.have) begin
			res_d.cluster_index = near_ext[OUT_IDX_W-1:0];
			res_d.cluster_label = b_end.lab;
		end
		case (op_q)
			OP_FORCE: want = 1'b1;
			OP_LEARN: want = !b_end.have || ({1'b0, b_end.dsq} >= {2'b00, radius_q});
			default:  want = 1'b0;
		endcase
		if (want) begin
			if (room) begin
				res_d.cluster_index = new_ext[OUT_IDX_W-1:0];
				res_d.cluster_label = lab_q;
				res_d.created       = 1'b1;
			end else begin
				res_d.table_full = 1'b1;
			end
		end else if ((op_q != OP_LEARN) && (op_q != OP_FORCE) && !b_end.have) begin
			res_d.table_empty = 1'b1;
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (b_end.valid) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Drive the head of the row and the table write
	always_comb begin
		q_head.valid = qv_q;
		q_head.x     = px_q;
		q_head.y     = py_q;
		b_head       = '0;
		b_head.valid = bv_q;
		wr.en        = finish && res_d.created;
		wr.addr      = count_q[IDX_W-1:0];
		wr.x         = px_q;
		wr.y         = py_q;
		wr.lab       = lab_q;
	end

	assign busy   = (state_q != ST_IDLE);
	assign count  = count_q;
	assign done   = done_q;
	assign result = result_q;

endmodule

@@ hw/rtl/leader_cluster_nearest_centroid.sv @@
// ----------------------------------------------------------------------------
// leader_cluster_nearest_centroid
// Leader clustering table with nearest-centroid search over a row of cells.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; its result
// word appears on result for exactly one cycle with done high and must be
// captured then, as there is no way to hold it off. The query walks the
// row of centroid cells one cell per cycle, with the running nearest match
// one cell behind it; busy stays high until the cycle of done, in which
// the next word may already be taken. The radius register may be written
// at any time through cfg_valid (cfg_ready is always high) but should
// only change while busy is low.
module leader_cluster_nearest_centroid (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  lccn_pkg::cmd_t             cmd,
	output logic                       done,
	output lccn_pkg::result_t          result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lccn_pkg::RAD_W-1:0] cfg_data
);
	import lccn_pkg::*;

	query_t           q_link [MAX_CENTROIDS+1];
	best_t            b_link [MAX_CENTROIDS+1];
	logic [CNT_W-1:0] count;
	wr_t              wr;

	assign cfg_ready = 1'b1;

	lccn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.b_end     (b_link[MAX_CENTROIDS]),
		.busy      (busy),
		.count     (count),
		.q_head    (q_link[0]),
		.b_head    (b_link[0]),
		.wr        (wr),
		.done      (done),
		.result    (result)
	);

	// Row of centroid cells
	for (genvar i = 0; i < MAX_CENTROIDS; i++) begin : g_cell
		lccn_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.live     (CNT_W'(i) < count),
			.wr_sel   (wr.en && (wr.addr == IDX_W'(i))),
			.wr       (wr),
			.q_in     (q_link[i]),
			.b_in     (b_link[i]),
			.q_out    (q_link[i+1]),
			.b_out    (b_link[i+1])
		);
	end

endmodule

@@ hw/rtl/lccn_checker.sv @@
// ----------------------------------------------------------------------------
// lccn_checker
// Port-level checks on command, result and busy timing of the block.
// ----------------------------------------------------------------------------
`include "leader_cluster_nearest_centroid_macros.svh"

module lccn_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input lccn_pkg::cmd_t             cmd,
	input logic                       done,
	input lccn_pkg::result_t          result,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [lccn_pkg::RAD_W-1:0] cfg_data
);
	import lccn_pkg::*;

	// Accepted word keeps the block busy
	`LCCN_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	// A result only follows a busy cycle
	`LCCN_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result word without work")
	// One result word per strobe, never back to back
	`LCCN_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
	// Create and drop never both
	`LCCN_ASSERT_SAME(a_flags_excl, done, !(result.created && result.table_full),
		"created and table_full together")
	// Empty classify or spare word: no create, no drop, index zero
	`LCCN_ASSERT_SAME(a_empty_clean, done && result.table_empty,
		!result.created && !result.table_full && (result.cluster_index == '0),
		"empty result carries other fields")

endmodule

bind leader_cluster_nearest_centroid lccn_checker u_lccn_checker (.*);

@@ bench/leader_cluster_nearest_centroid_tb.sv @@
// ----------------------------------------------------------------------------
// leader_cluster_nearest_centroid_tb
// Self-checking bench for the leader clustering table. Command words go in
// through start/busy, and every word is predicted here against a private
// copy of the centroid table and the join radius. Each result word, strobed
// by done, is matched field by field with the oldest prediction. Directed
// tests cover the empty table, coordinate extremes, nearest ties and the
// radius boundary. Random traffic then runs under several radius settings
// until the table is full and well past it.
// ----------------------------------------------------------------------------
module leader_cluster_nearest_centroid_tb;
	import lccn_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [RAD_W-1:0] RADIUS_MAX = {RAD_W{1'b1}};
	localparam logic [COORD_W-1:0] COORD_MIN = 16'h8000;
	localparam logic [COORD_W-1:0] COORD_MAX = 16'h7FFF;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	cmd_t             cmd = '0;
	logic             done;
	result_t          result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [RAD_W-1:0] cfg_data = '0;

	// Shadow of the centroid table and the radius register
	logic signed [COORD_W-1:0] tbl_x [MAX_CENTROIDS];
	logic signed [COORD_W-1:0] tbl_y [MAX_CENTROIDS];
	logic [1:0]                tbl_lab [MAX_CENTROIDS];
	int                        tbl_count = 0;
	logic [RAD_W-1:0]          radius_sq = RADIUS_RESET;

	result_t due_results [$];
	int      mismatch_count = 0;

	leader_cluster_nearest_centroid u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Work out the result of one command word and advance the shadow table
	function automatic result_t classify_point(input cmd_t c);
		result_t r;
		longint  dx, dy, d, best_d;
		int      i, best;
		logic    want;
		r = '0;
		best = 0;
		best_d = 0;
		for (i = 0; i < tbl_count; i++) begin
			dx = longint'(tbl_x[i]) - longint'(c.point_x);
			dy = longint'(tbl_y[i]) - longint'(c.point_y);
			d = dx * dx + dy * dy;
			if (i == 0 || d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		if (tbl_count > 0) begin
			r.cluster_index = best[OUT_IDX_W-1:0];
			r.cluster_label = tbl_lab[best];
		end
		if (c.opcode == OP_LEARN || c.opcode == OP_FORCE) begin
			want = (c.opcode == OP_FORCE) || (tbl_count == 0) ||
				(best_d >= longint'(radius_sq));
			if (want) begin
				if (tbl_count < MAX_CENTROIDS) begin
					tbl_x[tbl_count] = c.point_x;
					tbl_y[tbl_count] = c.point_y;
					tbl_lab[tbl_count] = c.point_label;
					r.cluster_index = tbl_count[OUT_IDX_W-1:0];
					r.cluster_label = c.point_label;
					r.created = 1'b1;
					tbl_count++;
				end else begin
					r.table_full = 1'b1;
				end
			end
		end else if (tbl_count == 0) begin
			r.table_empty = 1'b1;
		end
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
		if (v > 32767)
			return COORD_MAX;
		if (v < -32768)
			return COORD_MIN;
		return v[COORD_W-1:0];
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 15);
		return $urandom_range(20, 120);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < 50)
			$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Send one command word, predict it on acceptance, then idle for the given gap
	task automatic send_cmd(input logic [1:0] op, input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic [1:0] lab, input int gap);
		cmd_t    c;
		result_t r;
		c.opcode = op;
		c.point_x = x;
		c.point_y = y;
		c.point_label = lab;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		r = classify_point(c);
		due_results.insert(due_results.size(), r);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start and hold until every result word is in and the block is idle
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0 || busy);
	endtask

	task automatic write_radius(input logic [RAD_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radius_sq = value;
	endtask

	// Pick a point: near or on a stored centroid, anywhere, or from MIN, -1, 0 and MAX coordinates
	task automatic pick_point(output logic signed [COORD_W-1:0] x,
			output logic signed [COORD_W-1:0] y);
		int         mode, j, span;
		logic [31:0] raw;
		mode = $urandom_range(0, 99);
		if (tbl_count == 0 && mode < 70)
			mode = 80;
		if (mode < 70) begin
			j = $urandom_range(0, tbl_count - 1);
			case ($urandom_range(0, 3))
				0: span = 8;
				1: span = 400;
				2: span = 2000;
				default: span = 20000;
			endcase
			if (mode >= 55)
				span = 0;
			x = clamp_coord(int'(tbl_x[j]) + int'($urandom_range(0, 2 * span)) - span);
			y = clamp_coord(int'(tbl_y[j]) + int'($urandom_range(0, 2 * span)) - span);
		end else if (mode < 92) begin
			raw = $urandom();
			x = raw[15:0];
			y = raw[31:16];
		end else begin
			case ($urandom_range(0, 3))
				0: x = COORD_MIN;
				1: x = '1;
				2: x = '0;
				default: x = COORD_MAX;
			endcase
			case ($urandom_range(0, 3))
				0: y = COORD_MIN;
				1: y = '1;
				2: y = '0;
				default: y = COORD_MAX;
			endcase
		end
	endtask

	// Classify and the spare code on an empty table
	task automatic test_empty_table();
		send_cmd(OP_CLASSIFY, '0, '0, 2'd0, idle_cycles());
		send_cmd(OP_SPARE, '1, '1, 2'd3, idle_cycles());
	endtask

	// Opposite corners, widest distances, tie between two far centroids
	task automatic test_coordinate_extremes();
		send_cmd(OP_LEARN, COORD_MIN, COORD_MIN, 2'd0, idle_cycles());
		send_cmd(OP_FORCE, COORD_MAX, COORD_MAX, 2'd3, idle_cycles());
		send_cmd(OP_LEARN, COORD_MAX, COORD_MIN, 2'd1, idle_cycles());
		send_cmd(OP_CLASSIFY, COORD_MIN, COORD_MAX, 2'd2, idle_cycles());
	endtask

	// Learn next to a centroid, force that same point in, then query between them
	task automatic test_nearest_ties();
		send_cmd(OP_LEARN, -16'sd32668, COORD_MIN, 2'd1, idle_cycles());
		send_cmd(OP_FORCE, -16'sd32668, COORD_MIN, 2'd2, idle_cycles());
		send_cmd(OP_CLASSIFY, -16'sd32718, COORD_MIN, 2'd0, idle_cycles());
		send_cmd(OP_SPARE, 16'sd1, 16'sd1, 2'd1, idle_cycles());
	endtask

	// Distance exactly at the radius joins nothing; one unit inside does
	task automatic test_radius_boundary();
		send_cmd(OP_LEARN, '0, '0, 2'd1, idle_cycles());
		send_cmd(OP_LEARN, 16'sd384, '0, 2'd2, idle_cycles());
		send_cmd(OP_LEARN, 16'sd383, '0, 2'd3, idle_cycles());
	endtask

	// Zero radius adds every learn; the widest radius adds none
	task automatic test_radius_extremes();
		write_radius('0);
		send_cmd(OP_LEARN, '0, '0, 2'd0, idle_cycles());
		write_radius(RADIUS_MAX);
		send_cmd(OP_LEARN, 16'sd12345, -16'sd2000, 2'd1, idle_cycles());
		send_cmd(OP_FORCE, 16'sd12345, -16'sd2000, 2'd3, idle_cycles());
		write_radius(RADIUS_RESET);
	endtask

	// Random traffic under the current radius, with bursts of no idling
	task automatic test_random_traffic(input int count, input int pct_classify,
			input int pct_force);
		int                        n, r, gap;
		logic [1:0]                op;
		logic signed [COORD_W-1:0] x, y;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < pct_classify)
				op = ($urandom_range(0, 9) == 0) ? OP_SPARE : OP_CLASSIFY;
			else if (r < pct_classify + pct_force)
				op = OP_FORCE;
			else
				op = OP_LEARN;
			pick_point(x, y);
			gap = ((n / 40) % 4 == 0) ? 0 : idle_cycles();
			send_cmd(op, x, y, 2'($urandom_range(0, 3)), gap);
		end
	endtask

	// Match each result word against the oldest prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				report_mismatch("result word with none due", 0, 0);
			end else begin
				want = due_results.pop_front();
				if (result.cluster_index !== want.cluster_index)
					report_mismatch("cluster_index", result.cluster_index, want.cluster_index);
				if (result.cluster_label !== want.cluster_label)
					report_mismatch("cluster_label", result.cluster_label, want.cluster_label);
				if (result.created !== want.created)
					report_mismatch("created", result.created, want.created);
				if (result.table_full !== want.table_full)
					report_mismatch("table_full", result.table_full, want.table_full);
				if (result.table_empty !== want.table_empty)
					report_mismatch("table_empty", result.table_empty, want.table_empty);
			end
		end
	end

	initial begin
		#12000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_coordinate_extremes();
		test_nearest_ties();
		test_radius_boundary();
		test_radius_extremes();
		test_random_traffic(450, 50, 5);
		write_radius(33'($urandom_range(0, 4000000)));
		test_random_traffic(300, 40, 10);
		write_radius('0);
		test_random_traffic(150, 30, 20);
		write_radius(RADIUS_MAX);
		test_random_traffic(150, 40, 10);
		write_radius({1'($urandom_range(0, 1)), 32'($urandom())});
		test_random_traffic(250, 40, 10);
		// Drain, then watch for stray result words
		wait_idle();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
